[design/ipp_pkg.sv]
// ----------------------------------------------------------------------------
// ipp_pkg
// Types, phase and mark codes and character helpers for the address parser.
// ----------------------------------------------------------------------------
package ipp_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } ipp_in_t;

  typedef struct packed {
    logic        valid_res;
    logic        is_ipv6;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [15:0] port_number;
  } ipp_out_t;

  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_PLAIN  = 3'd1;
  localparam logic [2:0] PH_BHOST  = 3'd2;
  localparam logic [2:0] PH_BAFTER = 3'd3;
  localparam logic [2:0] PH_BPORT  = 3'd4;

  localparam logic [2:0] MK_NONE   = 3'd0;
  localparam logic [2:0] MK_GROUP  = 3'd1;
  localparam logic [2:0] MK_COLON  = 3'd2;
  localparam logic [2:0] MK_LEAD   = 3'd3;
  localparam logic [2:0] MK_DOUBLE = 3'd4;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic [16:0] PORT_MAX  = 17'd65535;
  localparam logic [8:0]  OCTET_MAX = 9'd255;

  // hex value in bits 3:0, bit 4 set when not a hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] n;
    n = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) n = {1'b0, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      n = {1'b0, c[3:0] + 4'd9};
    return n;
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39);
  endfunction

endpackage

[design/ip_address_text_parser_top.sv]
// ----------------------------------------------------------------------------
// ip_address_text_parser_top
// Parses IPv4 / IPv6 address text one character per request.
// ----------------------------------------------------------------------------
//  channel | ports                      | direction
//  input   | in_valid in_ready in_data  | one character and last marker
//  result  | out_valid out_ready out_data | one result per text
//
//  one character per cycle unless the input stalls; a text gives its result
//  in the cycle after its last character is accepted, from the result register
//  rst_n clears the parse state and the result valid flag, not the result data
//  the input stalls only while a result is held and not taken by the sink
//  a taken result frees the register in the same cycle a new request arrives
// ----------------------------------------------------------------------------
module ip_address_text_parser_top import ipp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ipp_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ipp_out_t out_data
);

  logic [2:0]  phase_r, phase_nxt;
  logic        err_r, err_nxt;
  logic [15:0] grp_r [8];
  logic [15:0] grp_nxt [8];
  logic [15:0] gval_r, gval_nxt;
  logic [2:0]  gdig_r, gdig_nxt;
  logic [3:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic        zfill_r, zfill_nxt;
  logic [2:0]  mark_r, mark_nxt;
  logic        v6bad_r, v6bad_nxt;
  logic [7:0]  oct_r [4];
  logic [7:0]  oct_nxt [4];
  logic [8:0]  oval_r, oval_nxt;
  logic [1:0]  oidx_r, oidx_nxt;
  logic        ohas_r, ohas_nxt;
  logic        v4bad_r, v4bad_nxt;
  logic [16:0] pval_r, pval_nxt;
  logic [2:0]  pdig_r, pdig_nxt;
  logic        colon_r, colon_nxt;
  logic        dot_r, dot_nxt;

  logic        out_valid_r;
  ipp_out_t    out_data_r, res;

  logic        take;
  logic [7:0]  c;
  logic [4:0]  nib;
  logic        dec;
  logic [3:0]  dval;
  logic [12:0] ov_wide;
  logic [20:0] pv_wide;

  assign in_ready  = !out_valid_r || out_ready;
  assign take      = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // next state for one character, then the finish pass on the last one
  always_comb begin
    logic [3:0] used;
    logic       v6_step, v4_step, port_step, is_last, valid, v6;
    logic [15:0] g [8];
    logic [3:0]  j;
    c    = in_data.char_code;
    nib  = hex_nibble(c);
    dec  = is_dec(c);
    dval = c[3:0];
    ov_wide = 13'(oval_r) * 13'd10 + 13'(dval);
    pv_wide = 21'(pval_r) * 21'd10 + 21'(dval);
    phase_nxt = phase_r; err_nxt = err_r; grp_nxt = grp_r; gval_nxt = gval_r;
    gdig_nxt = gdig_r; head_nxt = head_r; tail_nxt = tail_r; zfill_nxt = zfill_r;
    mark_nxt = mark_r; v6bad_nxt = v6bad_r; oct_nxt = oct_r; oval_nxt = oval_r;
    oidx_nxt = oidx_r; ohas_nxt = ohas_r; v4bad_nxt = v4bad_r; pval_nxt = pval_r;
    pdig_nxt = pdig_r; colon_nxt = colon_r; dot_nxt = dot_r;
    v6_step = 1'b0; v4_step = 1'b0; port_step = 1'b0;
    valid = 1'b0; v6 = 1'b1;
    res = '0;
    is_last = in_data.last_char;

    // phase dispatch
    if (phase_r == PH_START && c == CH_OPEN) begin
      phase_nxt = PH_BHOST;
    end else if (phase_r == PH_START || phase_r == PH_PLAIN) begin
      phase_nxt = PH_PLAIN;
      if (c == CH_DOT) dot_nxt = 1'b1;
      v4_step = 1'b1;
      v6_step = 1'b1;
    end else if (phase_r == PH_BHOST) begin
      if (c == CH_CLOSE) phase_nxt = PH_BAFTER;
      else v6_step = 1'b1;
    end else if (phase_r == PH_BAFTER) begin
      if (c == CH_COLON) phase_nxt = PH_BPORT;
      else err_nxt = 1'b1;
    end else begin
      port_step = !err_r;
    end

    // ipv4 reading and its port
    if (v4_step && !v4bad_r) begin
      if (!colon_r) begin
        if (dec) begin
          if (ov_wide > 13'(OCTET_MAX)) v4bad_nxt = 1'b1;
          else begin
            oval_nxt = ov_wide[8:0];
            ohas_nxt = 1'b1;
          end
        end else if (c == CH_DOT) begin
          if (!ohas_r || oidx_r == 2'd3) v4bad_nxt = 1'b1;
          else begin
            oct_nxt[oidx_r] = oval_r[7:0];
            oidx_nxt = oidx_r + 2'd1;
            oval_nxt = '0;
            ohas_nxt = 1'b0;
          end
        end else if (c == CH_COLON) begin
          colon_nxt = 1'b1;
          if (!ohas_r || oidx_r != 2'd3) v4bad_nxt = 1'b1;
          else oct_nxt[3] = oval_r[7:0];
        end else begin
          v4bad_nxt = 1'b1;
        end
      end else begin
        port_step = 1'b1;
      end
    end

    // port digits, shared by both port forms
    if (port_step) begin
      if (!dec || pdig_r >= 3'd5) begin
        if (phase_r == PH_BPORT) err_nxt = 1'b1;
        else v4bad_nxt = 1'b1;
      end else begin
        pval_nxt = pv_wide[16:0];
        pdig_nxt = pdig_r + 3'd1;
      end
    end

    // ipv6 reading
    used = head_r + tail_r;
    if (v6_step && !v6bad_r) begin
      if (!nib[4]) begin
        if (mark_r == MK_LEAD || gdig_r >= 3'd4) v6bad_nxt = 1'b1;
        else begin
          gval_nxt = {gval_r[11:0], nib[3:0]};
          gdig_nxt = gdig_r + 3'd1;
          mark_nxt = MK_GROUP;
        end
      end else if (c == CH_COLON) begin
        if (mark_r == MK_GROUP) begin
          if (used >= 4'd8) v6bad_nxt = 1'b1;
          else begin
            grp_nxt[used[2:0]] = gval_r;
            if (zfill_r) tail_nxt = tail_r + 4'd1;
            else head_nxt = head_r + 4'd1;
            gval_nxt = '0;
            gdig_nxt = '0;
            mark_nxt = MK_COLON;
          end
        end else if (mark_r == MK_NONE) begin
          mark_nxt = MK_LEAD;
        end else if (mark_r == MK_COLON || mark_r == MK_LEAD) begin
          if (zfill_r) v6bad_nxt = 1'b1;
          zfill_nxt = 1'b1;
          mark_nxt  = MK_DOUBLE;
        end else begin
          v6bad_nxt = 1'b1;
        end
      end else begin
        v6bad_nxt = 1'b1;
      end
    end

    // ipv6 finish: on ']' or at end of plain text
    if ((phase_r == PH_BHOST && c == CH_CLOSE) ||
        (is_last && phase_nxt == PH_PLAIN)) begin
      used = head_nxt + tail_nxt;
      if (!v6bad_nxt) begin
        if (mark_nxt == MK_GROUP) begin
          if (used >= 4'd8) v6bad_nxt = 1'b1;
          else begin
            grp_nxt[used[2:0]] = gval_nxt;
            if (zfill_nxt) tail_nxt = tail_nxt + 4'd1;
            else head_nxt = head_nxt + 4'd1;
          end
        end else if (mark_nxt != MK_DOUBLE) begin
          v6bad_nxt = 1'b1;
        end
        used = head_nxt + tail_nxt;
        if (!v6bad_nxt) begin
          if (zfill_nxt) begin
            if (used > 4'd7) v6bad_nxt = 1'b1;
          end else if (head_nxt != 4'd8) begin
            v6bad_nxt = 1'b1;
          end
        end
      end
    end

    // result assembly
    if (is_last && phase_nxt == PH_PLAIN) begin
      if (!v4bad_nxt) begin
        if (!colon_nxt) begin
          if (!ohas_nxt || oidx_nxt != 2'd3) v4bad_nxt = 1'b1;
          else oct_nxt[3] = oval_nxt[7:0];
        end else if (pdig_nxt == 3'd0 || pval_nxt > PORT_MAX) begin
          v4bad_nxt = 1'b1;
        end
      end
      if (dot_nxt) begin
        v6 = 1'b0;
        valid = !v4bad_nxt;
      end else begin
        valid = !v6bad_nxt;
      end
    end else if (phase_nxt == PH_BAFTER || phase_nxt == PH_BPORT) begin
      valid = !v6bad_nxt && !err_nxt;
      if (phase_nxt == PH_BPORT && (pdig_nxt == 3'd0 || pval_nxt > PORT_MAX))
        valid = 1'b0;
    end

    // zero-fill placement of the ipv6 groups
    for (int i = 0; i < 8; i++) begin
      j = 4'(i);
      g[i] = '0;
      if (j < head_nxt) g[i] = grp_nxt[i];
      else if (j + tail_nxt >= 4'd8) g[i] = grp_nxt[3'(head_nxt + j + tail_nxt - 4'd8)];
    end

    res.valid_res = valid;
    res.is_ipv6   = v6;
    if (valid && v6) begin
      res.addr_high = {g[0], g[1], g[2], g[3]};
      res.addr_low  = {g[4], g[5], g[6], g[7]};
    end
    if (valid && !v6) res.addr_low = {32'd0, oct_nxt[0], oct_nxt[1], oct_nxt[2], oct_nxt[3]};
    if (valid && ((!v6 && colon_nxt) || phase_nxt == PH_BPORT))
      res.port_number = pval_nxt[15:0];
  end

  // parse state; cleared after each last character
  always_ff @(posedge clk) begin
    if (!rst_n || (take && in_data.last_char)) begin
      phase_r <= PH_START; err_r <= 1'b0; gval_r <= '0; gdig_r <= '0;
      head_r <= '0; tail_r <= '0; zfill_r <= 1'b0; mark_r <= MK_NONE;
      v6bad_r <= 1'b0; oval_r <= '0; oidx_r <= '0; ohas_r <= 1'b0;
      v4bad_r <= 1'b0; pval_r <= '0; pdig_r <= '0; colon_r <= 1'b0; dot_r <= 1'b0;
      for (int i = 0; i < 8; i++) grp_r[i] <= '0;
      for (int i = 0; i < 4; i++) oct_r[i] <= '0;
    end else if (take) begin
      phase_r <= phase_nxt; err_r <= err_nxt; gval_r <= gval_nxt; gdig_r <= gdig_nxt;
      head_r <= head_nxt; tail_r <= tail_nxt; zfill_r <= zfill_nxt; mark_r <= mark_nxt;
      v6bad_r <= v6bad_nxt; oval_r <= oval_nxt; oidx_r <= oidx_nxt; ohas_r <= ohas_nxt;
      v4bad_r <= v4bad_nxt; pval_r <= pval_nxt; pdig_r <= pdig_nxt;
      colon_r <= colon_nxt; dot_r <= dot_nxt;
      grp_r <= grp_nxt;
      oct_r <= oct_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && in_data.last_char) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_data.last_char) begin
      out_data_r <= res;
    end
  end

  // checks
  a_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");
  a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_data.last_char |=> phase_r == PH_START && head_r == 4'd0)
    else $error("parse state not cleared after last character");
  a_groups: assert property (@(posedge clk) disable iff (!rst_n)
    head_r + tail_r <= 4'd8)
    else $error("group count overflow");
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.valid_res |-> out_data.addr_low == 64'd0 &&
    out_data.port_number == 16'd0)
    else $error("invalid result carries data");

endmodule

[dv/tb_ip_address_text_parser_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ip_address_text_parser_top
// Feeds address text one character per request, mostly well-formed IPv4,
// IPv6 and bracketed forms with random content plus corrupted and random
// byte noise, and checks every parse result against an in-bench parser.
// ----------------------------------------------------------------------------
module tb_ip_address_text_parser_top;
  import ipp_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  ipp_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  ipp_out_t out_data;

  ip_address_text_parser_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  ipp_in_t  char_q[$];
  ipp_out_t parse_q[$];
  int       hold_q[$];
  int       mismatches;
  int       idle_cycles;
  int       in_gap;
  int       out_gap;
  bit       in_took;
  bit       feed_done;
  bit       timed_out;

  // predictor state
  logic [2:0]  p_phase;
  bit          p_err;
  logic [15:0] p_grp[8];
  logic [15:0] p_gval;
  int          p_gdig;
  int          p_head;
  int          p_tail;
  bit          p_fill;
  logic [2:0]  p_mark;
  bit          p_v6bad;
  logic [7:0]  p_oct[4];
  int          p_oval;
  int          p_oidx;
  bit          p_ohas;
  bit          p_v4bad;
  int          p_port;
  int          p_pdig;
  int          p_colons;
  bit          p_dot;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int nib_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return 16;
  endfunction

  function automatic bit dec_char(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void clear_parse();
    p_phase = PH_START; p_err = 0;
    foreach (p_grp[i]) p_grp[i] = '0;
    p_gval = '0; p_gdig = 0; p_head = 0; p_tail = 0; p_fill = 0;
    p_mark = MK_NONE; p_v6bad = 0;
    foreach (p_oct[i]) p_oct[i] = '0;
    p_oval = 0; p_oidx = 0; p_ohas = 0; p_v4bad = 0;
    p_port = 0; p_pdig = 0; p_colons = 0; p_dot = 0;
  endfunction

  function automatic bit take_port_digit(logic [7:0] c);
    if (p_pdig >= 5) return 0;
    p_port = p_port * 10 + (c - "0");
    p_pdig++;
    return 1;
  endfunction

  function automatic void close_group();
    if (p_head + p_tail >= 8) begin
      p_v6bad = 1;
      return;
    end
    p_grp[(p_head + p_tail) % 8] = p_gval;
    if (p_fill) p_tail++; else p_head++;
    p_gval = '0; p_gdig = 0;
  endfunction

  function automatic void v6_feed(logic [7:0] c);
    int n;
    if (p_v6bad) return;
    n = nib_of(c);
    if (n < 16) begin
      if (p_mark == MK_LEAD || p_gdig >= 4) begin
        p_v6bad = 1;
        return;
      end
      p_gval = {p_gval[11:0], n[3:0]};
      p_gdig++;
      p_mark = MK_GROUP;
    end else if (c == CH_COLON) begin
      if (p_mark == MK_GROUP) begin
        close_group();
        p_mark = MK_COLON;
      end else if (p_mark == MK_NONE) begin
        p_mark = MK_LEAD;
      end else if (p_mark == MK_COLON || p_mark == MK_LEAD) begin
        if (p_fill) p_v6bad = 1;
        p_fill = 1;
        p_mark = MK_DOUBLE;
      end else begin
        p_v6bad = 1;
      end
    end else begin
      p_v6bad = 1;
    end
  endfunction

  function automatic void v6_end();
    if (p_v6bad) return;
    if (p_mark == MK_GROUP) close_group();
    else if (p_mark != MK_DOUBLE) p_v6bad = 1;
    if (p_v6bad) return;
    if (p_fill) begin
      if (p_head + p_tail > 7) p_v6bad = 1;
    end else if (p_head != 8) begin
      p_v6bad = 1;
    end
  endfunction

  function automatic void v4_host_end();
    if (!p_ohas || p_oidx != 3) begin
      p_v4bad = 1;
      return;
    end
    p_oct[3] = p_oval[7:0];
  endfunction

  function automatic void v4_feed(logic [7:0] c);
    int v;
    if (p_v4bad) return;
    if (p_colons == 0) begin
      if (dec_char(c)) begin
        v = p_oval * 10 + (c - "0");
        if (v > 255) begin
          p_v4bad = 1;
          return;
        end
        p_oval = v; p_ohas = 1;
      end else if (c == CH_DOT) begin
        if (!p_ohas || p_oidx >= 3) begin
          p_v4bad = 1;
          return;
        end
        p_oct[p_oidx] = p_oval[7:0];
        p_oidx++; p_oval = 0; p_ohas = 0;
      end else if (c == CH_COLON) begin
        p_colons = 1;
        v4_host_end();
      end else begin
        p_v4bad = 1;
      end
    end else if (!dec_char(c) || !take_port_digit(c)) begin
      p_v4bad = 1;
    end
  endfunction

  function automatic logic [63:0] v6_word(int first);
    logic [63:0] r;
    logic [15:0] g;
    r = '0;
    for (int i = first; i < first + 4; i++) begin
      g = '0;
      if (i < p_head) g = p_grp[i % 8];
      else if (i + p_tail >= 8) g = p_grp[(p_head + i + p_tail - 8) % 8];
      r = {r[47:0], g};
    end
    return r;
  endfunction

  // advances the parser by one character, queueing a result on the last one
  function automatic void parse_char(ipp_in_t d);
    ipp_out_t r;
    logic [7:0] c;
    bit ok;
    bit port_ok;
    c = d.char_code;
    if (p_phase == PH_START && c == CH_OPEN) begin
      p_phase = PH_BHOST;
    end else if (p_phase == PH_START || p_phase == PH_PLAIN) begin
      p_phase = PH_PLAIN;
      if (c == CH_DOT) p_dot = 1;
      v4_feed(c);
      v6_feed(c);
    end else if (p_phase == PH_BHOST) begin
      if (c == CH_CLOSE) begin
        v6_end();
        p_phase = PH_BAFTER;
      end else begin
        v6_feed(c);
      end
    end else if (p_phase == PH_BAFTER) begin
      if (c == CH_COLON) p_phase = PH_BPORT;
      else p_err = 1;
    end else if (!p_err && (!dec_char(c) || !take_port_digit(c))) begin
      p_err = 1;
    end
    if (!d.last_char) return;
    r = '0;
    r.is_ipv6 = 1'b1;
    ok = 0;
    if (p_phase == PH_PLAIN) begin
      if (!p_v4bad) begin
        if (p_colons == 0) v4_host_end();
        else if (!(p_pdig >= 1 && p_port <= 65535)) p_v4bad = 1;
      end
      v6_end();
      if (p_dot) begin
        r.is_ipv6 = 1'b0;
        ok = !p_v4bad;
        if (ok) begin
          r.addr_low = {32'd0, p_oct[0], p_oct[1], p_oct[2], p_oct[3]};
          if (p_colons != 0) r.port_number = p_port[15:0];
        end
      end else begin
        ok = !p_v6bad;
      end
    end else if (p_phase == PH_BAFTER || p_phase == PH_BPORT) begin
      port_ok = p_pdig >= 1 && p_port <= 65535;
      ok = !p_v6bad && !p_err;
      if (p_phase == PH_BPORT && !port_ok) ok = 0;
      if (ok && p_phase == PH_BPORT) r.port_number = p_port[15:0];
    end
    if (ok && r.is_ipv6) begin
      r.addr_high = v6_word(0);
      r.addr_low  = v6_word(4);
    end
    r.valid_res = ok;
    parse_q.push_back(r);
    clear_parse();
  endfunction

  // ---- text builders ----
  function automatic void push_text(string s, int hold = 0);
    ipp_in_t d;
    for (int i = 0; i < s.len(); i++) begin
      d.char_code = s[i];
      d.last_char = (i == s.len() - 1);
      char_q.push_back(d);
      hold_q.push_back((i == 0) ? hold : 0);
    end
  endfunction

  function automatic string rand_hex_group();
    string s, h;
    int n;
    s = "";
    n = $urandom_range(1, 4);
    h = ($urandom_range(0, 1) != 0) ? "0123456789abcdef" : "0123456789ABCDEF";
    for (int i = 0; i < n; i++) s = {s, string'(h[$urandom_range(0, 15)])};
    return s;
  endfunction

  function automatic string rand_octet();
    int v;
    v = ($urandom_range(0, 3) == 0) ? $urandom_range(250, 255) : $urandom_range(0, 255);
    if ($urandom_range(0, 7) == 0) return $sformatf("0%0d", v);
    return $sformatf("%0d", v);
  endfunction

  function automatic string rand_port();
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) return $sformatf("%0d", $urandom_range(65530, 65539));
    if (r == 1) return $sformatf("%0d", $urandom_range(0, 9));
    if (r == 2) return "00443";
    return $sformatf("%0d", $urandom_range(0, 65535));
  endfunction

  function automatic string rand_v6();
    string s;
    int n;
    int split;
    s = "";
    if ($urandom_range(0, 2) == 0) begin
      for (int i = 0; i < 8; i++) s = {s, (i > 0) ? ":" : "", rand_hex_group()};
      return s;
    end
    n = $urandom_range(0, 7);
    split = $urandom_range(0, n);
    for (int i = 0; i < split; i++) s = {s, (i > 0) ? ":" : "", rand_hex_group()};
    s = {s, "::"};
    for (int i = split; i < n; i++) s = {s, (i > split) ? ":" : "", rand_hex_group()};
    return s;
  endfunction

  function automatic string mangle(string s);
    int k;
    k = $urandom_range(0, s.len() - 1);
    s[k] = $urandom_range(0, 255);
    return s;
  endfunction

  function automatic string rand_text();
    string s;
    string pool;
    int r;
    pool = ":.[]0aF9x";
    r = $urandom_range(0, 9);
    case (r)
      0, 1: begin
        s = {rand_octet(), ".", rand_octet(), ".", rand_octet(), ".", rand_octet()};
        if ($urandom_range(0, 1) != 0) s = {s, ":", rand_port()};
      end
      2, 3: s = rand_v6();
      4, 5: begin
        s = {"[", rand_v6(), "]"};
        if ($urandom_range(0, 1) != 0) s = {s, ":", rand_port()};
      end
      6: begin
        s = "";
        for (int i = $urandom_range(1, 12); i > 0; i--)
          s = {s, string'(pool[$urandom_range(0, 8)])};
      end
      7: begin
        s = "";
        for (int i = $urandom_range(1, 8); i > 0; i--) s = {s, " "};
        for (int i = 0; i < s.len(); i++) s[i] = $urandom_range(1, 255);
      end
      default: s = mangle(($urandom_range(0, 1) != 0) ? {"[", rand_v6(), "]:80"} :
                          {rand_octet(), ".1.2.", rand_octet()});
    endcase
    return s;
  endfunction

  // ---- stimulus ----
  initial begin
    int n_chars;
    string s;
    ipp_in_t d;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0; out_ready = 1'b0;
    feed_done = 0; mismatches = 0; in_took = 0;
    clear_parse();
    // directed: extremes, each form, each special case
    push_text("255.255.255.255:65535");
    push_text("0.0.0.0");
    push_text("000192.168.001.1:0");
    push_text("256.1.1.1");
    push_text("1.2.3.4:65536");
    push_text("1.2.3.4:123456");
    push_text("1.2.3");
    push_text("ffff:FFFF:0:1:2:3:4:abcd");
    push_text("::");
    push_text("::1");
    push_text("fe80::");
    push_text("1::2::3");
    push_text("12345::1");
    push_text("1:2:3:4:5:6:7:8:9");
    push_text("1:2:3:4::5:6:7:8");
    push_text("[2001:db8::1]:8080");
    push_text("[::]");
    push_text("[::1");
    push_text("[::1]x");
    push_text("[::1]:");
    push_text("1.2.[3.4");
    push_text("1.2.3.4]");
    push_text("1:2:3:4:5:6:7:8:80");
    d.char_code = 8'hFF; d.last_char = 1'b1;
    char_q.push_back(d); hold_q.push_back(0);
    // drain before the random part
    push_text("::ffff", 1);
    n_chars = char_q.size();
    while (n_chars < 1600) begin
      s = rand_text();
      push_text(s, ($urandom_range(0, 60) == 0) ? 1 : 0);
      n_chars += s.len();
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    feed_done = 1;
  end

  // driver: presents characters, changing inputs on the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_took || !in_valid) begin
        if (in_took) begin
          char_q.pop_front();
          hold_q.pop_front();
          in_gap = $urandom_range(0, 3);
        end
        if (char_q.size() == 0 || in_gap > 0 ||
            (hold_q.size() > 0 && hold_q[0] != 0 && parse_q.size() != 0)) begin
          if (in_gap > 0) in_gap--;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data  <= char_q[0];
        end
      end
      in_took = 0;
      // sink side stall
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor: samples on the rising edge and checks results
  always @(posedge clk) begin
    ipp_out_t want;
    if (!rst_n) begin
      idle_cycles <= 0;
      in_gap = 0; out_gap = 0; in_took = 0;
    end else begin
      if (in_valid && in_ready) begin
        parse_char(in_data);
        in_took = 1;
      end
      if (out_valid && out_ready) begin
        out_gap = $urandom_range(0, 3);
        if (parse_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result %p", out_data);
        end else begin
          want = parse_q.pop_front();
          if (want.valid_res !== out_data.valid_res || want.is_ipv6 !== out_data.is_ipv6 ||
              want.addr_high !== out_data.addr_high || want.addr_low !== out_data.addr_low ||
              want.port_number !== out_data.port_number) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p actual %p", want, out_data);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // end of run and watchdog
  initial begin
    timed_out = 0;
    wait (feed_done);
    while ((char_q.size() != 0 || parse_q.size() != 0) && !timed_out) begin
      @(posedge clk);
      if (idle_cycles >= STALL_LIMIT) timed_out = 1;
    end
    if (timed_out) begin
      $display("SCOREBOARD MISMATCH");
    end else begin
      repeat (20) @(posedge clk);
      if (mismatches == 0) begin
        $display("SCOREBOARD CLEAN");
      end else begin
        $display("SCOREBOARD MISMATCH");
      end
    end
    $finish;
  end

endmodule
